[rtl/pmqs_pkg.sv]
// shared types and constants of the priority message queue scheduler
`default_nettype none
package pmqs_pkg;

  localparam int TABLE_DEPTH_DEF     = 16;
  localparam int PRIORITY_LEVELS_DEF = 4;
  localparam int TASK_COUNT          = 5;
  localparam int HOST_MAILBOX        = 2;

  localparam int CFG_W     = 10;
  localparam int PRI_EXT_W = 16;
  localparam int TASK_W    = 3;
  localparam int HANDLE_W  = 4;
  localparam int MBX_W     = 3;
  localparam int ENTRY_W   = MBX_W + HANDLE_W;

  typedef enum logic {
    ACT_SEND = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  typedef struct packed {
    logic take_item;
    logic commit_send;
    logic commit_pop;
    logic load_popped;
  } pmqs_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic pop_hit;
  } pmqs_stat_t;

endpackage
`default_nettype wire

[rtl/pmqs_in_if.sv]
// input item channel
`default_nettype none
interface pmqs_in_if;
  import pmqs_pkg::*;

  logic                valid;
  logic                ready;
  action_t             action;
  logic [TASK_W-1:0]   task_id;
  logic [HANDLE_W-1:0] message_handle;

  modport source (output valid, action, task_id, message_handle, input ready);
  modport sink   (input valid, action, task_id, message_handle, output ready);
endinterface
`default_nettype wire

[rtl/pmqs_out_if.sv]
// result item channel
`default_nettype none
interface pmqs_out_if;
  import pmqs_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [MBX_W-1:0]    out_mailbox;
  logic [HANDLE_W-1:0] out_message;

  modport source (output valid, status, out_mailbox, out_message, input ready);
  modport sink   (input valid, status, out_mailbox, out_message, output ready);
endinterface
`default_nettype wire

[rtl/pmqs_cfg_if.sv]
// configuration write channel
`default_nettype none
interface pmqs_cfg_if;
  import pmqs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] task_priorities;

  modport source (output valid, task_priorities, input ready);
  modport sink   (input valid, task_priorities, output ready);
endinterface
`default_nettype wire

[rtl/pmqs_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module pmqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/pmqs_ctrl.sv]
// controller state machine of the scheduler
`default_nettype none
module pmqs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire pmqs_pkg::pmqs_stat_t stat,
  output      pmqs_pkg::pmqs_cmd_t  cmd
);
  import pmqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = (stat.is_pop && stat.pop_hit) ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      S_EXEC: begin
        cmd.commit_send = out_free && !stat.is_pop;
        cmd.commit_pop  = out_free && stat.is_pop;
      end
      S_READ: begin
        cmd.load_popped = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit_send || (cmd.commit_pop && !stat.pop_hit) || cmd.load_popped) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[rtl/pmqs_dp.sv]
// datapath: priority register, ring pointers, entry ram and result register
`default_nettype none
module pmqs_dp #(
  parameter int TABLE_DEPTH     = pmqs_pkg::TABLE_DEPTH_DEF,
  parameter int PRIORITY_LEVELS = pmqs_pkg::PRIORITY_LEVELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pmqs_pkg::CFG_W-1:0]      cfg_data,
  input  wire pmqs_pkg::action_t               in_action,
  input  wire logic [pmqs_pkg::TASK_W-1:0]     in_task_id,
  input  wire logic [pmqs_pkg::HANDLE_W-1:0]   in_handle,
  input  wire pmqs_pkg::pmqs_cmd_t             cmd,
  output      pmqs_pkg::pmqs_stat_t            stat,
  output      pmqs_pkg::status_t               res_status,
  output      logic [pmqs_pkg::MBX_W-1:0]      res_mailbox,
  output      logic [pmqs_pkg::HANDLE_W-1:0]   res_message
);
  import pmqs_pkg::*;

  localparam int LVL_W  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int PTR_W  = $clog2(TABLE_DEPTH);
  localparam int ADDR_W = LVL_W + PTR_W;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  logic [CFG_W-1:0]    prio_r;
  action_t             action_r;
  logic [TASK_W-1:0]   task_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PTR_W-1:0]    rptr_r [PRIORITY_LEVELS];
  logic [PTR_W-1:0]    wptr_r [PRIORITY_LEVELS];
  logic [PTR_W-1:0]    rptr_nxt [PRIORITY_LEVELS];
  logic [PTR_W-1:0]    wptr_nxt [PRIORITY_LEVELS];
  status_t             status_r, status_nxt;
  logic [MBX_W-1:0]    mbx_r, mbx_nxt;
  logic [HANDLE_W-1:0] msg_r, msg_nxt;

  logic [PRI_EXT_W-1:0] prio_shift;
  logic [1:0]           raw_lvl;
  logic [2:0]           clamp_lvl;
  logic [LVL_W-1:0]     send_lvl;
  logic [PTR_W-1:0]     wnext;
  logic                 bad_task;
  logic                 full;
  logic                 drop;
  logic [MBX_W-1:0]     send_mbx;
  logic                 pop_hit;
  logic [LVL_W-1:0]     pop_lvl;
  logic [PTR_W-1:0]     rnext;
  logic                 ram_we;
  logic                 ram_re;
  logic [ENTRY_W-1:0]   ram_rdata;

  // send side: level lookup and full check
  assign prio_shift = PRI_EXT_W'(prio_r) >> {task_r, 1'b0};
  assign raw_lvl    = prio_shift[1:0];
  assign clamp_lvl  = (int'(raw_lvl) >= PRIORITY_LEVELS) ? 3'(PRIORITY_LEVELS - 1)
                                                         : {1'b0, raw_lvl};
  assign send_lvl   = clamp_lvl[LVL_W-1:0];
  assign wnext      = ring_next(wptr_r[send_lvl]);
  assign bad_task   = int'(task_r) >= TASK_COUNT;
  assign full       = wnext == rptr_r[send_lvl];
  assign drop       = bad_task || full;
  assign send_mbx   = (int'(task_r) == HOST_MAILBOX - 1) ? MBX_W'(HOST_MAILBOX) : task_r;

  // pop side: the non-empty ring with the lowest level number
  always_comb begin
    pop_hit = 1'b0;
    pop_lvl = '0;
    for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
      if (rptr_r[l] != wptr_r[l]) begin
        pop_hit = 1'b1;
        pop_lvl = LVL_W'(l);
      end
    end
  end

  assign rnext = ring_next(rptr_r[pop_lvl]);

  assign stat.is_pop  = action_r == ACT_POP;
  assign stat.pop_hit = pop_hit;

  assign ram_we = cmd.commit_send && !drop;
  assign ram_re = cmd.commit_pop && pop_hit;

  pmqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   ({send_lvl, wnext}),
    .wdata   ({send_mbx, handle_r}),
    .re      (ram_re),
    .raddr   ({pop_lvl, rnext}),
    .rdata_r (ram_rdata)
  );

  always_comb begin
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      rptr_nxt[l] = rptr_r[l];
      wptr_nxt[l] = wptr_r[l];
    end
    if (ram_we) wptr_nxt[send_lvl] = wnext;
    if (ram_re) rptr_nxt[pop_lvl]  = rnext;
  end

  always_comb begin
    status_nxt = status_r;
    mbx_nxt    = mbx_r;
    msg_nxt    = msg_r;
    if (cmd.commit_send) begin
      status_nxt = drop ? ST_DROPPED : ST_QUEUED;
      mbx_nxt    = '0;
      msg_nxt    = '0;
    end else if (cmd.commit_pop && !pop_hit) begin
      status_nxt = ST_EMPTY;
      mbx_nxt    = '0;
      msg_nxt    = '0;
    end else if (cmd.load_popped) begin
      status_nxt = ST_POPPED;
      mbx_nxt    = ram_rdata[ENTRY_W-1:HANDLE_W];
      msg_nxt    = ram_rdata[HANDLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= '0;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        rptr_r[l] <= '0;
        wptr_r[l] <= '0;
      end
    end else begin
      if (cfg_we) prio_r <= cfg_data;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        rptr_r[l] <= rptr_nxt[l];
        wptr_r[l] <= wptr_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      action_r <= in_action;
      task_r   <= in_task_id;
      handle_r <= in_handle;
    end
    status_r <= status_nxt;
    mbx_r    <= mbx_nxt;
    msg_r    <= msg_nxt;
  end

  assign res_status  = status_r;
  assign res_mailbox = mbx_r;
  assign res_message = msg_r;

endmodule
`default_nettype wire

[rtl/priority_message_queue_scheduler_core.sv]
// Strict-priority message scheduler: a send item is queued in the ring of its task's
// configured level; a pop item returns the oldest entry of the lowest-numbered
// non-empty level. Items are handled one at a time: a send, or a pop that finds every
// ring empty, is accepted, then executed into the result register; a pop that finds an
// entry goes on to a read state for the registered read of the entry ram. The next item
// is taken once the controller is back in idle; the result register lets it be taken
// while the previous result still waits, but execution stalls while that register is
// full. Each ring holds TABLE_DEPTH-1 entries; a send to a full ring or an unknown task
// is dropped with a dropped status. The configuration port is always ready.
`default_nettype none
module priority_message_queue_scheduler_core #(
  parameter int TABLE_DEPTH     = pmqs_pkg::TABLE_DEPTH_DEF,
  parameter int PRIORITY_LEVELS = pmqs_pkg::PRIORITY_LEVELS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  pmqs_in_if.sink     in_if,
  pmqs_out_if.source  out_if,
  pmqs_cfg_if.sink    cfg_if
);
  import pmqs_pkg::*;

  pmqs_cmd_t  cmd;
  pmqs_stat_t stat;
  logic       in_fire;

  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;

  pmqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pmqs_dp #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_if.valid),
    .cfg_data    (cfg_if.task_priorities),
    .in_action   (in_if.action),
    .in_task_id  (in_if.task_id),
    .in_handle   (in_if.message_handle),
    .cmd         (cmd),
    .stat        (stat),
    .res_status  (out_if.status),
    .res_mailbox (out_if.out_mailbox),
    .res_message (out_if.out_message)
  );

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("input taken while an item is still in work");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_POPPED) |->
      (out_if.out_mailbox == '0 && out_if.out_message == '0))
    else $error("result fields not zero on a non-pop status");

  a_host_remapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status == ST_POPPED) |->
      (int'(out_if.out_mailbox) != HOST_MAILBOX - 1))
    else $error("popped mailbox id was not remapped");

  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit_send || cmd.commit_pop) |=> !(cmd.commit_send || cmd.commit_pop))
    else $error("item committed twice");
`endif

endmodule
`default_nettype wire

[sim/tb.sv]
// testbench of the priority message queue scheduler core with a self-checking scoreboard
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmqs_pkg::*;

  localparam int RING_DEPTH   = TABLE_DEPTH_DEF;
  localparam int LEVEL_COUNT  = PRIORITY_LEVELS_DEF;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 4;
  localparam int PHASE_ITEMS  = 550;

  typedef struct packed {
    status_t             status;
    logic [MBX_W-1:0]    mailbox;
    logic [HANDLE_W-1:0] message;
  } sched_result_t;

  class sched_scoreboard;
    logic [CFG_W-1:0]    task_levels;
    int                  rd_slot[LEVEL_COUNT];
    int                  wr_slot[LEVEL_COUNT];
    logic [MBX_W-1:0]    mbx_ring[LEVEL_COUNT][RING_DEPTH];
    logic [HANDLE_W-1:0] hdl_ring[LEVEL_COUNT][RING_DEPTH];
    sched_result_t       pending_outcomes[$];
    int                  mismatches;

    function new();
      task_levels = '0;
      mismatches  = 0;
      foreach (rd_slot[i]) begin
        rd_slot[i] = 0;
        wr_slot[i] = 0;
      end
    endfunction

    function void write_levels(logic [CFG_W-1:0] value);
      task_levels = value;
    endfunction

    function void note_item(action_t act, logic [TASK_W-1:0] tid,
                            logic [HANDLE_W-1:0] hdl);
      sched_result_t outcome;
      int            lvl;
      int            nxt;
      bit            found;
      outcome = '0;
      found   = 0;
      if (act == ACT_SEND) begin
        if (int'(tid) >= TASK_COUNT) begin
          outcome.status = ST_DROPPED;
        end else begin
          lvl = int'((task_levels >> (2 * int'(tid))) & 10'd3);
          if (lvl >= LEVEL_COUNT) lvl = LEVEL_COUNT - 1;
          nxt = (wr_slot[lvl] + 1) % RING_DEPTH;
          if (nxt == rd_slot[lvl]) begin
            outcome.status = ST_DROPPED;
          end else begin
            mbx_ring[lvl][nxt] = (int'(tid) == HOST_MAILBOX - 1) ? MBX_W'(HOST_MAILBOX) : tid;
            hdl_ring[lvl][nxt] = hdl;
            wr_slot[lvl]       = nxt;
            outcome.status     = ST_QUEUED;
          end
        end
      end else begin
        outcome.status = ST_EMPTY;
        for (lvl = 0; lvl < LEVEL_COUNT && !found; lvl++) begin
          if (rd_slot[lvl] != wr_slot[lvl]) begin
            nxt             = (rd_slot[lvl] + 1) % RING_DEPTH;
            outcome.status  = ST_POPPED;
            outcome.mailbox = mbx_ring[lvl][nxt];
            outcome.message = hdl_ring[lvl][nxt];
            rd_slot[lvl]    = nxt;
            found           = 1;
          end
        end
      end
      pending_outcomes.push_back(outcome);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(status_t st, logic [MBX_W-1:0] mbx, logic [HANDLE_W-1:0] msg);
      sched_result_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result transfer with no item outstanding");
        return;
      end
      want = pending_outcomes.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (mbx !== want.mailbox)
        report_mismatch($sformatf("mailbox %0d, want %0d", mbx, want.mailbox));
      if (msg !== want.message)
        report_mismatch($sformatf("message %0d, want %0d", msg, want.message));
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              quiet_cycles;
  sched_scoreboard sb;

  pmqs_in_if  in_if();
  pmqs_out_if out_if();
  pmqs_cfg_if cfg_if();

  priority_message_queue_scheduler_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.status, out_if.out_mailbox, out_if.out_message);
      if (in_if.valid && in_if.ready)
        sb.note_item(in_if.action, in_if.task_id, in_if.message_handle);
      if (cfg_if.valid && cfg_if.ready)
        sb.write_levels(cfg_if.task_priorities);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("priority_message_queue_scheduler_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(action_t act, logic [TASK_W-1:0] tid, logic [HANDLE_W-1:0] hdl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.action         <= act;
    in_if.task_id        <= tid;
    in_if.message_handle <= hdl;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_priorities(logic [CFG_W-1:0] value);
    drain_results();
    cfg_if.valid           <= 1'b1;
    cfg_if.task_priorities <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random(int count);
    int                  send_bias;
    action_t             act;
    logic [TASK_W-1:0]   tid;
    logic [HANDLE_W-1:0] hdl;
    send_bias = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0:       send_bias = 85;
          1:       send_bias = 50;
          default: send_bias = 15;
        endcase
      end
      if ($urandom_range(299) == 0) drain_results();
      act = ($urandom_range(99) < send_bias) ? ACT_SEND : ACT_POP;
      tid = ($urandom_range(9) == 0) ? TASK_W'($urandom_range(7, 5))
                                     : TASK_W'($urandom_range(4));
      hdl = HANDLE_W'($urandom_range(15));
      send_item(act, tid, hdl);
    end
  endtask

  initial begin
    sb                     = new();
    rst_n                  = 1'b0;
    quiet_cycles           = 0;
    send_idle_pct          = 24;
    recv_idle_pct          = 76;
    in_if.valid            = 1'b0;
    in_if.action           = ACT_SEND;
    in_if.task_id          = '0;
    in_if.message_handle   = '0;
    out_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.task_priorities = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // task 0 and 4 on level 0, task 2 on 1, task 3 on 2, task 1 on 3
    set_priorities(10'h09C);
    send_item(ACT_POP, 3'd0, 4'd0);
    send_item(ACT_SEND, 3'd0, 4'd0);
    send_item(ACT_SEND, 3'd1, 4'd15);
    send_item(ACT_SEND, 3'd2, 4'd10);
    send_item(ACT_SEND, 3'd3, 4'd5);
    send_item(ACT_SEND, 3'd4, 4'd15);
    send_item(ACT_SEND, 3'd7, 4'd15);
    send_item(ACT_SEND, 3'd5, 4'd0);
    send_item(ACT_POP, 3'd7, 4'd15);
    send_item(ACT_POP, 3'd0, 4'd0);
    // queued entries stay put, then level 3 overflows
    set_priorities(10'h3FF);
    for (int i = 0; i < 15; i++) send_item(ACT_SEND, 3'd2, HANDLE_W'(15 - i));

    set_priorities(CFG_W'($urandom_range(1023)));
    run_random(PHASE_ITEMS);

    send_idle_pct = 76;
    recv_idle_pct = 24;
    set_priorities(10'h000);
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_priorities(CFG_W'($urandom_range(1023)));
    run_random(PHASE_ITEMS);

    in_if.valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0) begin
      $display("priority_message_queue_scheduler_core test passed");
    end else begin
      $display("priority_message_queue_scheduler_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
